>>> hdl/circular_deque_macros.svh
// ----------------------------------------------------------------------------
// circular deque assertion macros
// shared assertion forms for the deque checker
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// checked only while out of reset
`define CDQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("circular_deque assertion failed");

// checked on every edge, reset included
`define CDQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("circular_deque assertion failed");

`endif

>>> hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// types and constants shared by the circular deque modules
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic clear;
        logic shift_right;
        logic shift_left;
        logic load_rear;
        logic pop_rear;
    } t_cell_ctl;

endpackage

>>> hdl/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// one deque entry: holds a value and a valid bit, trades with its neighbors
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cdq_pkg::t_cell_ctl        i_ctl,
    input  logic [cdq_pkg::DATA_W-1:0] i_push_value,
    input  logic [cdq_pkg::DATA_W-1:0] i_left_value,
    input  logic                      i_left_valid,
    input  logic [cdq_pkg::DATA_W-1:0] i_right_value,
    input  logic                      i_right_valid,
    output logic [cdq_pkg::DATA_W-1:0] o_value,
    output logic                      o_valid,
    output logic [cdq_pkg::DATA_W-1:0] o_next_value,
    output logic                      o_next_valid
);

    logic [cdq_pkg::DATA_W-1:0] r_value;
    logic [cdq_pkg::DATA_W-1:0] n_value;
    logic                       r_valid;
    logic                       n_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift_right) begin
            n_value = i_left_value;
            n_valid = i_left_valid;
        end else if (i_ctl.shift_left) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.load_rear) begin
            if (!r_valid && i_left_valid) begin
                n_value = i_push_value;
                n_valid = 1'b1;
            end
        end else if (i_ctl.pop_rear) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_valid      = r_valid;
    assign o_next_value = n_value;
    assign o_next_valid = n_valid;

endmodule

>>> hdl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// bounded double-ended queue of 32-bit values built from a row of cells
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) carries one request per transaction:
// push front, push rear, pop front, pop rear or query. output channel
// (o_out_valid / i_out_ready) returns one status per request: accepted flag,
// front and rear values (all ones when empty), empty and full flags after it.
// a push when full or a pop when empty is refused and leaves the deque as is.
// the status is registered and shown in the cycle after the request is taken.
// throughput: one request per cycle while the output register is not stalled;
// the whole cell row updates in the cycle a request is taken, front sitting in
// cell 0 and rear in the last valid cell. the output register holds its status
// while i_out_ready is low, and a new request is taken whenever that register is free or drains in the same cycle.
// i_cfg_we with i_cfg_wdata sets the capacity (0 acts as 1, above DEPTH acts
// as DEPTH) and empties the deque; write it only while the block is idle.
// reset: deque empty, capacity 16, no status pending.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [cdq_pkg::REQ_W-1:0]  i_in_req_type,
    input  logic [cdq_pkg::DATA_W-1:0] i_in_push_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_out_accepted,
    output logic [cdq_pkg::DATA_W-1:0] o_out_front_value,
    output logic [cdq_pkg::DATA_W-1:0] o_out_rear_value,
    output logic                       o_out_is_empty,
    output logic                       o_out_is_full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [cdq_pkg::CAP_W-1:0]  r_cap;
    logic [31:0]                w_cap_ext;
    logic [31:0]                w_last_idx32;
    logic [IDX_W-1:0]           w_last_idx;

    logic [cdq_pkg::DATA_W-1:0] w_value      [DEPTH];
    logic [cdq_pkg::DATA_W-1:0] w_next_value [DEPTH];
    logic [DEPTH-1:0]           w_valid;
    logic [DEPTH-1:0]           w_next_valid;
    logic [DEPTH:0]             w_next_valid_ext;

    cdq_pkg::t_cell_ctl         w_ctl;
    logic                       w_fire;
    logic                       w_ok;
    logic                       w_empty;
    logic                       w_full;

    logic [cdq_pkg::DATA_W-1:0] w_rear_or;
    logic [cdq_pkg::DATA_W-1:0] w_next_front;
    logic [cdq_pkg::DATA_W-1:0] w_next_rear;
    logic                       w_next_empty;
    logic                       w_next_full;

    logic                       r_out_valid;
    logic                       r_accepted;
    logic [cdq_pkg::DATA_W-1:0] r_front;
    logic [cdq_pkg::DATA_W-1:0] r_rear;
    logic                       r_empty;
    logic                       r_full;

    // capacity, clamped into 1..DEPTH, as the index of the last usable cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cdq_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_cap_ext = 32'(r_cap);
        if (w_cap_ext == 32'd0) begin
            w_last_idx32 = 32'd0;
        end else if (w_cap_ext > 32'(DEPTH)) begin
            w_last_idx32 = 32'(DEPTH - 1);
        end else begin
            w_last_idx32 = w_cap_ext - 32'd1;
        end
        w_last_idx = w_last_idx32[IDX_W-1:0];
    end

    assign w_fire  = i_in_valid && o_in_ready;
    assign w_empty = !w_valid[0];
    assign w_full  = w_valid[w_last_idx];

    // request decode
    always_comb begin
        w_ctl       = '0;
        w_ctl.clear = i_cfg_we;
        w_ok        = 1'b0;
        case (i_in_req_type)
            cdq_pkg::REQ_PUSH_FRONT: begin
                w_ok              = !w_full;
                w_ctl.shift_right = w_fire && w_ok;
            end
            cdq_pkg::REQ_PUSH_REAR: begin
                w_ok            = !w_full;
                w_ctl.load_rear = w_fire && w_ok;
            end
            cdq_pkg::REQ_POP_FRONT: begin
                w_ok             = !w_empty;
                w_ctl.shift_left = w_fire && w_ok;
            end
            cdq_pkg::REQ_POP_REAR: begin
                w_ok           = !w_empty;
                w_ctl.pop_rear = w_fire && w_ok;
            end
            cdq_pkg::REQ_QUERY: begin
                w_ok = 1'b1;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [cdq_pkg::DATA_W-1:0] w_lv;
            logic                       w_lvld;
            logic [cdq_pkg::DATA_W-1:0] w_rv;
            logic                       w_rvld;

            if (g == 0) begin : g_left_end
                assign w_lv   = i_in_push_value;
                assign w_lvld = 1'b1;
            end else begin : g_left
                assign w_lv   = w_value[g-1];
                assign w_lvld = w_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_right_end
                assign w_rv   = '0;
                assign w_rvld = 1'b0;
            end else begin : g_right
                assign w_rv   = w_value[g+1];
                assign w_rvld = w_valid[g+1];
            end

            cdq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_push_value  (i_in_push_value),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lvld),
                .i_right_value (w_rv),
                .i_right_valid (w_rvld),
                .o_value       (w_value[g]),
                .o_valid       (w_valid[g]),
                .o_next_value  (w_next_value[g]),
                .o_next_valid  (w_next_valid[g])
            );
        end
    endgenerate

    // status after the request, taken from the cells' next state
    assign w_next_valid_ext = {1'b0, w_next_valid};

    always_comb begin
        w_rear_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_next_valid_ext[i] && !w_next_valid_ext[i+1]) begin
                w_rear_or = w_rear_or | w_next_value[i];
            end
        end
    end

    assign w_next_empty = !w_next_valid[0];
    assign w_next_full  = w_next_valid[w_last_idx];
    assign w_next_front = w_next_empty ? cdq_pkg::EMPTY_VALUE : w_next_value[0];
    assign w_next_rear  = w_next_empty ? cdq_pkg::EMPTY_VALUE : w_rear_or;

    // output register
    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_accepted <= w_ok;
            r_front    <= w_next_front;
            r_rear     <= w_next_rear;
            r_empty    <= w_next_empty;
            r_full     <= w_next_full;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_accepted    = r_accepted;
    assign o_out_front_value = r_front;
    assign o_out_rear_value  = r_rear;
    assign o_out_is_empty    = r_empty;
    assign o_out_is_full     = r_full;

endmodule

>>> hdl/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// port-level checks on the circular deque, bound to the top level
// ----------------------------------------------------------------------------
`include "circular_deque_macros.svh"

module cdq_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    input  logic                       o_in_ready,
    input  logic [cdq_pkg::REQ_W-1:0]  i_in_req_type,
    input  logic [cdq_pkg::DATA_W-1:0] i_in_push_value,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic                       o_out_accepted,
    input  logic [cdq_pkg::DATA_W-1:0] o_out_front_value,
    input  logic [cdq_pkg::DATA_W-1:0] o_out_rear_value,
    input  logic                       o_out_is_empty,
    input  logic                       o_out_is_full
);

    // no status pending right after reset
    `CDQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid)

    // a stalled status holds its valid flag, front and rear values and empty flag
    `CDQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_front_value) && $stable(o_out_rear_value) && $stable(o_out_is_empty))

    // an empty deque reports all ones at both ends
    `CDQ_ASSERT(a_empty_values, i_clk, i_rst_n, o_out_valid && o_out_is_empty |-> o_out_front_value == cdq_pkg::EMPTY_VALUE && o_out_rear_value == cdq_pkg::EMPTY_VALUE)

    // capacity is at least one, so empty and full never coincide
    `CDQ_ASSERT(a_empty_not_full, i_clk, i_rst_n, o_out_valid |-> !(o_out_is_empty && o_out_is_full))

    // a query request is always accepted
    `CDQ_ASSERT(a_query_ok, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_req_type == cdq_pkg::REQ_QUERY |=> o_out_valid && o_out_accepted)

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

>>> sim/circular_deque_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// self-checking bench for the bounded deque: a driver sends push, pop, query
// and unknown requests under random gaps and output stalls. a ring predictor
// works out the status each transaction should return. the monitor compares
// every returned status field by field, across several capacity settings.
// ----------------------------------------------------------------------------
module circular_deque_tb;

    localparam int DEPTH = 16;

    typedef logic [cdq_pkg::REQ_W-1:0]  t_req;
    typedef logic [cdq_pkg::CAP_W-1:0]  t_cap;
    typedef logic [cdq_pkg::DATA_W-1:0] t_data;

    localparam t_req REQ_UNKNOWN_FIRST = 3'd5;
    localparam t_req REQ_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic  accepted;
        t_data front;
        t_data rear;
        logic  empty;
        logic  full;
    } t_status;

    typedef struct {
        t_req  req;
        t_data value;
    } t_request;

    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  i_cfg_we        = 1'b0;
    t_cap  i_cfg_wdata     = '0;
    logic  i_in_valid      = 1'b0;
    logic  o_in_ready;
    t_req  i_in_req_type   = '0;
    t_data i_in_push_value = '0;
    logic  o_out_valid;
    logic  i_out_ready     = 1'b0;
    logic  o_out_accepted;
    t_data o_out_front_value;
    t_data o_out_rear_value;
    logic  o_out_is_empty;
    logic  o_out_is_full;

    t_request    request_q[$];
    t_status     status_q[$];
    int          err_cnt = 0;

    // predictor state
    t_data             ring[DEPTH];
    int unsigned       head       = 0;
    int unsigned       tail       = 0;
    bit                ring_empty = 1'b1;
    t_cap              cap_reg    = cdq_pkg::CAP_RESET;

    int  in_gap   = 0;
    int  out_stall = 0;
    bit  in_idle  = 1'b0;
    bit  out_idle = 1'b0;

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_req_type     (i_in_req_type),
        .i_in_push_value   (i_in_push_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_accepted    (o_out_accepted),
        .o_out_front_value (o_out_front_value),
        .o_out_rear_value  (o_out_rear_value),
        .o_out_is_empty    (o_out_is_empty),
        .o_out_is_full     (o_out_is_full)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit ring_full(input int unsigned c);
        return !ring_empty && ((tail + 1) % c) == head;
    endfunction

    function automatic void apply_request(input t_req req, input t_data val);
        int unsigned c;
        t_status     st;
        c = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        st.accepted = 1'b0;
        case (req)
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_REAR: begin
                if (!ring_full(c)) begin
                    if (ring_empty) begin
                        head = 0;
                        tail = 0;
                        ring_empty = 1'b0;
                        ring[0] = val;
                    end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
                        head = (head + c - 1) % c;
                        ring[head] = val;
                    end else begin
                        tail = (tail + 1) % c;
                        ring[tail] = val;
                    end
                    st.accepted = 1'b1;
                end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_REAR: begin
                if (!ring_empty) begin
                    if (head == tail) begin
                        head = 0;
                        tail = 0;
                        ring_empty = 1'b1;
                    end else if (req == cdq_pkg::REQ_POP_FRONT) begin
                        head = (head + 1) % c;
                    end else begin
                        tail = (tail + c - 1) % c;
                    end
                    st.accepted = 1'b1;
                end
            end
            cdq_pkg::REQ_QUERY: st.accepted = 1'b1;
            default: ;
        endcase
        st.front = ring_empty ? cdq_pkg::EMPTY_VALUE : ring[head];
        st.rear  = ring_empty ? cdq_pkg::EMPTY_VALUE : ring[tail];
        st.empty = ring_empty;
        st.full  = ring_full(c);
        status_q.push_back(st);
    endfunction

    function automatic void add_item(input t_req req, input t_data val);
        t_request r;
        r.req = req;
        r.value = val;
        request_q.push_back(r);
    endfunction

    task automatic fill_random(input int n);
        int    push_bias;
        int    roll;
        t_req  req;
        t_data val;
        push_bias = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 24 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_bias = 15;
                    1: push_bias = 50;
                    default: push_bias = 85;
                endcase
            end
            roll = int'($urandom_range(0, 99));
            if (roll < 4)
                req = t_req'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
            else if (roll < 12)
                req = cdq_pkg::REQ_QUERY;
            else if ($urandom_range(0, 99) < push_bias)
                req = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_REAR
                                           : cdq_pkg::REQ_PUSH_FRONT;
            else
                req = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_REAR
                                           : cdq_pkg::REQ_POP_FRONT;
            case ($urandom_range(0, 19))
                0: val = 32'h7fff_ffff;
                1: val = 32'h8000_0000;
                2: val = '1;
                3: val = '0;
                default: val = $urandom();
            endcase
            add_item(req, val);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || status_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_capacity(input t_cap v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cap_reg     = v;
        head        = 0;
        tail        = 0;
        ring_empty  = 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin : driver
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                apply_request(i_in_req_type, i_in_push_value);
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    i_in_valid      <= 1'b1;
                    i_in_req_type   <= nxt.req;
                    i_in_push_value <= nxt.value;
                    if ($urandom_range(0, 39) == 0)
                        in_idle = !in_idle;
                    in_gap = in_idle ? int'($urandom_range(0, 10)) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_out_accepted, o_out_front_value, o_out_rear_value,
                       o_out_is_empty, o_out_is_full};
                if (status_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected status transaction: acc=%0b front=%h rear=%h",
                                 got.accepted, got.front, got.rear);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("status mismatch: expected acc=%0b front=%h rear=%h empty=%0b full=%0b",
                                     want.accepted, want.front, want.rear, want.empty,
                                     want.full);
                            $display("                 actual   acc=%0b front=%h rear=%h empty=%0b full=%0b",
                                     got.accepted, got.front, got.rear, got.empty,
                                     got.full);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    out_idle = !out_idle;
                out_stall = out_idle ? int'($urandom_range(0, 10)) : 0;
                i_out_ready <= (out_stall == 0);
            end else if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= (out_stall == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_cap cap_plan[8];
        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd17, 5'd0, 5'd8, 5'd16};
        cap_plan[6] = t_cap'($urandom_range(4, 15));
        for (int i = 0; i < DEPTH; i++)
            ring[i] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty deque, extremes, unknown codes, draining from both ends
        add_item(cdq_pkg::REQ_QUERY, $urandom());
        add_item(cdq_pkg::REQ_POP_FRONT, $urandom());
        add_item(cdq_pkg::REQ_POP_REAR, $urandom());
        add_item(cdq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
        add_item(cdq_pkg::REQ_PUSH_REAR, 32'h8000_0000);
        add_item(cdq_pkg::REQ_PUSH_FRONT, 32'hffff_ffff);
        add_item(cdq_pkg::REQ_PUSH_REAR, 32'h0000_0000);
        add_item(cdq_pkg::REQ_QUERY, 32'h0000_0000);
        add_item(REQ_UNKNOWN_FIRST, $urandom());
        add_item(REQ_UNKNOWN_FIRST + 3'd1, $urandom());
        add_item(REQ_UNKNOWN_LAST, $urandom());
        add_item(cdq_pkg::REQ_POP_FRONT, $urandom());
        add_item(cdq_pkg::REQ_POP_REAR, $urandom());
        add_item(cdq_pkg::REQ_POP_FRONT, $urandom());
        add_item(cdq_pkg::REQ_POP_REAR, $urandom());
        add_item(cdq_pkg::REQ_POP_FRONT, $urandom());

        // small capacity: full refusal
        write_capacity(5'd2);
        add_item(cdq_pkg::REQ_PUSH_REAR, 32'h1234_5678);
        add_item(cdq_pkg::REQ_PUSH_FRONT, 32'hdead_beef);
        add_item(cdq_pkg::REQ_PUSH_REAR, 32'h5555_aaaa);
        add_item(REQ_UNKNOWN_LAST, $urandom());
        add_item(cdq_pkg::REQ_POP_REAR, $urandom());
        add_item(cdq_pkg::REQ_POP_REAR, $urandom());
        add_item(cdq_pkg::REQ_POP_REAR, $urandom());

        // zero capacity acts as one
        write_capacity(5'd0);
        add_item(cdq_pkg::REQ_PUSH_FRONT, 32'haaaa_5555);
        add_item(cdq_pkg::REQ_PUSH_REAR, $urandom());
        add_item(cdq_pkg::REQ_POP_FRONT, $urandom());

        foreach (cap_plan[i]) begin
            write_capacity(cap_plan[i]);
            fill_random(75);
        end

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (err_cnt == 0 && status_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque.sv
hdl/cdq_checker.sv
sim/circular_deque_tb.sv
